>>> sv/amq_pkg.sv
// Shared types and constants for the array min priority queue.
// Used by amq_ctrl, amq_dpath and array_min_priority_queue; depends on nothing.
`default_nettype none

package amq_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_WEIGHT_BITS  = 32;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Operation codes carried in the request.
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DECREASE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

  // Per-vertex status codes.
  localparam logic [STATUS_W-1:0] ENT_UNSEEN = 2'd0;
  localparam logic [STATUS_W-1:0] ENT_FRINGE = 2'd1;
  localparam logic [STATUS_W-1:0] ENT_TREE   = 2'd2;

  // Register index of vertex_count (paddr bit 2 and up).
  localparam logic [APB_AW-3:0] REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_FIND,
    ST_EXEC
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic issue_req;
    logic issue_min;
    logic scan_start;
    logic scan_step;
    logic scan_done;
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_scan;
    logic use_cache;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/amq_ctrl.sv
// Sequencing state machine of the priority queue.
// Depends on amq_pkg; drives amq_dpath through amq_pkg::cmd_t.
`default_nettype none

module amq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire amq_pkg::sts_t sts_i,
  output amq_pkg::cmd_t      cmd_o
);

  amq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      amq_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = amq_pkg::ST_DISPATCH;
      end
      amq_pkg::ST_DISPATCH: begin
        state_d = sts_i.needs_scan ? amq_pkg::ST_SCAN : amq_pkg::ST_EXEC;
      end
      amq_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = amq_pkg::ST_DRAIN;
      end
      amq_pkg::ST_DRAIN: state_d = amq_pkg::ST_FIND;
      // The cached minimum is now valid, so dispatch again to read it.
      amq_pkg::ST_FIND:  state_d = amq_pkg::ST_DISPATCH;
      amq_pkg::ST_EXEC: begin
        if (sts_i.out_free) state_d = amq_pkg::ST_IDLE;
      end
      default: state_d = amq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      amq_pkg::ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.accept  = req_valid_i;
      end
      amq_pkg::ST_DISPATCH: begin
        cmd_o.scan_start = sts_i.needs_scan;
        cmd_o.issue_min  = !sts_i.needs_scan && sts_i.use_cache;
        cmd_o.issue_req  = !sts_i.needs_scan && !sts_i.use_cache;
      end
      amq_pkg::ST_SCAN:  cmd_o.scan_step = 1'b1;
      amq_pkg::ST_DRAIN: cmd_o           = '0;
      amq_pkg::ST_FIND:  cmd_o.scan_done = 1'b1;
      amq_pkg::ST_EXEC:  cmd_o.exec      = sts_i.out_free;
      default:           cmd_o           = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/amq_dpath.sv
// Datapath of the priority queue: entry memory, valid bits, scan unit,
// cached minimum, configuration register and result register. Depends on amq_pkg.
`default_nettype none

module amq_dpath #(
  parameter int MAX_VERTICES = amq_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = amq_pkg::DEF_WEIGHT_BITS,
  localparam int VW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire amq_pkg::cmd_t                cmd_i,
  output amq_pkg::sts_t                     sts_o,
  input  wire logic [amq_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [VW-1:0]                vertex_i,
  input  wire logic [VW-1:0]                parent_in_i,
  input  wire logic [WEIGHT_BITS-1:0]       weight_in_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [VW-1:0]                cfg_wdata_i,
  output logic [VW-1:0]                     vertex_count_o,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output logic [VW-1:0]                     removed_vertex_o,
  output logic [WEIGHT_BITS-1:0]            removed_weight_o,
  output logic [VW-1:0]                     removed_parent_o,
  output logic [amq_pkg::STATUS_W-1:0]      read_status_o,
  output logic [WEIGHT_BITS-1:0]            read_weight_o,
  output logic [VW-1:0]                     read_parent_o,
  output logic [VW-1:0]                     queue_count_o,
  output logic                              queue_empty_o,
  output logic                              error_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int SW = amq_pkg::STATUS_W;
  localparam int MW = SW + VW + WEIGHT_BITS;
  localparam logic [VW-1:0] MAXV = VW'(MAX_VERTICES);

  // Entry word: {status, parent, weight}.
  logic [MW-1:0] entry_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] ent_valid_q;
  logic [MW-1:0] rd_data_q;
  logic          rd_valid_q;

  logic [VW-1:0]             vc_q;
  logic [amq_pkg::MODE_W-1:0] req_mode_q;
  logic [VW-1:0]             req_vertex_q, req_parent_q;
  logic [WEIGHT_BITS-1:0]    req_weight_q;

  logic [VW-1:0]          count_q, count_d;
  logic [VW-1:0]          cache_min_q;
  logic                   cache_valid_q;
  logic [VW-1:0]          scan_cnt_q, best_q;
  logic [WEIGHT_BITS-1:0] best_w_q;
  logic                   cmp_valid_q;
  logic [VW-1:0]          cmp_vertex_q;
  logic                   res_valid_q;

  logic [VW-1:0]          n_act;
  logic                   req_in_range, scan_issue;
  logic                   rd_en, rd_ok, mem_we, op_ok, take;
  logic [VW-1:0]          rd_vertex, wr_vertex;
  logic [AW-1:0]          rd_idx, wr_idx;
  logic [MW-1:0]          wr_word;
  logic [SW-1:0]          rd_status;
  logic [VW-1:0]          rd_parent;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic                   is_ins, is_dec, is_del, is_read, is_clr;

  assign n_act        = (vc_q > MAXV) ? MAXV : vc_q;
  assign req_in_range = (req_vertex_q != '0) && (req_vertex_q <= n_act);
  assign scan_issue   = scan_cnt_q <= n_act;

  assign rd_weight = rd_data_q[WEIGHT_BITS-1:0];
  assign rd_parent = rd_data_q[WEIGHT_BITS +: VW];
  // A never-written or cleared entry reads as unseen.
  assign rd_status = rd_valid_q ? rd_data_q[MW-1 -: SW] : amq_pkg::ENT_UNSEEN;

  assign is_ins  = req_mode_q == amq_pkg::MODE_INSERT;
  assign is_dec  = req_mode_q == amq_pkg::MODE_DECREASE;
  assign is_del  = req_mode_q == amq_pkg::MODE_DELETE;
  assign is_read = req_mode_q == amq_pkg::MODE_READ;
  assign is_clr  = req_mode_q == amq_pkg::MODE_CLEAR;

  assign sts_o.needs_scan = is_del && !cache_valid_q && (count_q != '0);
  assign sts_o.use_cache  = is_del && cache_valid_q;
  assign sts_o.scan_last  = scan_cnt_q >= n_act;
  assign sts_o.out_free   = !res_valid_q || res_ready_i;

  // Read port address.
  always_comb begin
    rd_en = cmd_i.issue_req || cmd_i.issue_min || (cmd_i.scan_step && scan_issue);
    if (cmd_i.issue_min) begin
      rd_vertex = cache_min_q;
    end else if (cmd_i.scan_step) begin
      rd_vertex = scan_cnt_q;
    end else begin
      rd_vertex = req_vertex_q;
    end
    rd_ok  = (rd_vertex != '0) && (rd_vertex <= MAXV);
    rd_idx = rd_ok ? AW'(rd_vertex - VW'(1)) : '0;
  end

  // Legality and update of the executed request.
  always_comb begin
    case (req_mode_q)
      amq_pkg::MODE_INSERT:   op_ok = req_in_range && (rd_status == amq_pkg::ENT_UNSEEN);
      amq_pkg::MODE_DECREASE: op_ok = req_in_range && (rd_status == amq_pkg::ENT_FRINGE);
      amq_pkg::MODE_DELETE:   op_ok = (count_q != '0) && cache_valid_q && (cache_min_q != '0);
      amq_pkg::MODE_READ:     op_ok = req_in_range;
      amq_pkg::MODE_CLEAR:    op_ok = 1'b1;
      default:                op_ok = 1'b0;
    endcase
    mem_we    = cmd_i.exec && op_ok && (is_ins || is_dec || is_del);
    wr_vertex = is_del ? cache_min_q : req_vertex_q;
    wr_idx    = AW'(wr_vertex - VW'(1));
    if (is_del) begin
      wr_word = {amq_pkg::ENT_TREE, rd_parent, rd_weight};
    end else begin
      wr_word = {amq_pkg::ENT_FRINGE, req_parent_q, req_weight_q};
    end
    count_d = count_q;
    if (op_ok) begin
      if (is_ins) count_d = count_q + VW'(1);
      else if (is_del) count_d = count_q - VW'(1);
      else if (is_clr) count_d = '0;
    end
  end

  assign take = cmp_valid_q && (rd_status == amq_pkg::ENT_FRINGE) &&
                ((best_q == '0) || (rd_weight < best_w_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem[wr_idx] <= wr_word;
    if (rd_en) rd_data_q <= entry_mem[rd_idx];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_mode_q   <= mode_i;
      req_vertex_q <= vertex_i;
      req_parent_q <= parent_in_i;
      req_weight_q <= weight_in_i;
    end
    if (cmd_i.scan_step) cmp_vertex_q <= scan_cnt_q;
    if (take) best_w_q <= rd_weight;
    if (cmd_i.exec) begin
      removed_vertex_o <= (is_del && op_ok) ? cache_min_q : '0;
      removed_weight_o <= (is_del && op_ok) ? rd_weight : '0;
      removed_parent_o <= (is_del && op_ok) ? rd_parent : '0;
      read_status_o    <= (is_read && op_ok) ? rd_status : '0;
      read_weight_o    <= (is_read && op_ok) ? rd_weight : '0;
      read_parent_o    <= (is_read && op_ok) ? rd_parent : '0;
      queue_count_o    <= count_d;
      queue_empty_o    <= count_d == '0;
      error_o          <= !op_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q          <= MAXV;
      ent_valid_q   <= '0;
      rd_valid_q    <= 1'b0;
      count_q       <= '0;
      cache_min_q   <= '0;
      cache_valid_q <= 1'b0;
      scan_cnt_q    <= '0;
      best_q        <= '0;
      cmp_valid_q   <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (rd_en) rd_valid_q <= ent_valid_q[rd_idx];
      if (cmd_i.exec && op_ok && is_clr) begin
        ent_valid_q <= '0;
      end else if (mem_we) begin
        ent_valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.exec) count_q <= count_d;

      cmp_valid_q <= cmd_i.scan_step && scan_issue;
      if (cmd_i.scan_start) begin
        scan_cnt_q <= VW'(1);
        best_q     <= '0;
      end else begin
        if (cmd_i.scan_step) scan_cnt_q <= scan_cnt_q + VW'(1);
        if (take) best_q <= cmp_vertex_q;
      end

      if (cfg_we_i) begin
        vc_q          <= cfg_wdata_i;
        cache_valid_q <= 1'b0;
        cache_min_q   <= '0;
      end else if (cmd_i.scan_done) begin
        cache_min_q   <= best_q;
        cache_valid_q <= 1'b1;
      end else if (cmd_i.exec && op_ok && !is_read) begin
        // Any change of the entries drops the cached minimum.
        cache_valid_q <= 1'b0;
        cache_min_q   <= '0;
      end

      if (cmd_i.exec) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o    = res_valid_q;
  assign vertex_count_o = vc_q;

endmodule

`default_nettype wire

>>> sv/array_min_priority_queue.sv
// Array based min priority queue: top level with stream ports and APB register.
// Depends on amq_pkg, amq_ctrl and amq_dpath.
//
// Usage: requests enter on the s_axis channel (mode, vertex, parent, weight),
// one result per request leaves on the m_axis channel. Modes are insert,
// decrease key, delete min, read entry and clear all; illegal requests set
// the error field and change nothing. vertex_count is written over APB at
// address 0; the user must write it only while no request is in flight,
// which the block itself does not enforce. Insert, decrease key, read,
// clear and a delete min whose minimum is cached go from dispatch straight
// to execution. A delete min without a cached minimum scans entries 1 to n
// (n is vertex_count capped at MAX_VERTICES) through the single read port
// of the entry memory, one per cycle, before it executes.
// One request is worked on at a time; the next request is taken once the
// result has been moved into the output register, while that result waits.
// Reset empties the queue (all vertices unseen) and sets vertex_count to
// MAX_VERTICES; it takes effect at once, with no clearing pass.
// When the receiver stalls, the result is held and at most one further
// request is accepted, which then waits until the output register frees.
`default_nettype none

module array_min_priority_queue #(
  parameter int MAX_VERTICES = amq_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = amq_pkg::DEF_WEIGHT_BITS,
  localparam int VW     = $clog2(MAX_VERTICES + 1),
  localparam int IN_RAW = amq_pkg::MODE_W + 2 * VW + WEIGHT_BITS,
  localparam int IN_DW  = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = 4 * VW + 2 * WEIGHT_BITS + amq_pkg::STATUS_W + 2,
  localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // mode, vertex, parent_in, weight_in (lowest bits first)
  input  wire logic [IN_DW-1:0]           s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // removed_vertex, removed_weight, removed_parent, read_status, read_weight,
  // read_parent, queue_count, queue_empty, error (lowest bits first)
  output logic [OUT_DW-1:0]               m_axis_tdata,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [amq_pkg::APB_AW-1:0] paddr,
  input  wire logic [amq_pkg::APB_DW-1:0] pwdata,
  output logic [amq_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int MODE_W = amq_pkg::MODE_W;

  amq_pkg::cmd_t cmd;
  amq_pkg::sts_t sts;

  logic [VW-1:0]          vertex_count;
  logic                   reg_sel, cfg_we;
  logic [VW-1:0]          o_rem_vertex, o_rem_parent, o_rd_parent, o_count;
  logic [WEIGHT_BITS-1:0] o_rem_weight, o_rd_weight;
  logic [amq_pkg::STATUS_W-1:0] o_rd_status;
  logic                   o_empty, o_error;

  assign pready  = 1'b1;
  assign reg_sel = paddr[amq_pkg::APB_AW-1:2] == amq_pkg::REG_VERTEX_COUNT;
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? amq_pkg::APB_DW'(vertex_count) : '0;

  amq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  amq_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (s_axis_tdata[MODE_W-1:0]),
    .vertex_i         (s_axis_tdata[MODE_W +: VW]),
    .parent_in_i      (s_axis_tdata[MODE_W + VW +: VW]),
    .weight_in_i      (s_axis_tdata[MODE_W + 2 * VW +: WEIGHT_BITS]),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (pwdata[VW-1:0]),
    .vertex_count_o   (vertex_count),
    .res_valid_o      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .removed_vertex_o (o_rem_vertex),
    .removed_weight_o (o_rem_weight),
    .removed_parent_o (o_rem_parent),
    .read_status_o    (o_rd_status),
    .read_weight_o    (o_rd_weight),
    .read_parent_o    (o_rd_parent),
    .queue_count_o    (o_count),
    .queue_empty_o    (o_empty),
    .error_o          (o_error)
  );

  assign m_axis_tdata = OUT_DW'({o_error, o_empty, o_count, o_rd_parent, o_rd_weight,
                                 o_rd_status, o_rem_parent, o_rem_weight, o_rem_vertex});

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_count <= VW'(MAX_VERTICES)))
    else $error("queue count exceeds the vertex capacity");

  a_error_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && o_error) |-> (o_rem_vertex == '0))
    else $error("failed request reports a removed vertex");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  a_removal_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (o_rem_vertex != '0)) |-> !o_error)
    else $error("removal flagged as error");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for array_min_priority_queue: drives requests and the
// vertex_count register, predicts every result and compares it. Depends on amq_pkg.

module testbench;

  localparam int VW             = 9;
  localparam int WB             = amq_pkg::DEF_WEIGHT_BITS;
  localparam int MAXV           = amq_pkg::DEF_MAX_VERTICES;
  localparam int MODE_W         = amq_pkg::MODE_W;
  localparam int STATUS_W       = amq_pkg::STATUS_W;
  localparam int APB_AW         = amq_pkg::APB_AW;
  localparam int APB_DW         = amq_pkg::APB_DW;
  localparam int IN_DW          = ((MODE_W + 2 * VW + WB + 7) / 8) * 8;
  localparam int OUT_DW         = ((4 * VW + 2 * WB + STATUS_W + 2 + 7) / 8) * 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 300;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [APB_AW-1:0] VC_ADDR        = {amq_pkg::REG_VERTEX_COUNT, 2'b00};

  typedef enum int {PICK_UNSEEN, PICK_FRINGE, PICK_WRITTEN} pick_e;

  // Fields from the lowest bit up: mode, vertex, parent, weight.
  typedef struct packed {
    logic [WB-1:0]     weight;
    logic [VW-1:0]     parent;
    logic [VW-1:0]     vertex;
    logic [MODE_W-1:0] mode;
  } pq_req_t;

  typedef struct packed {
    logic                error;
    logic                queue_empty;
    logic [VW-1:0]       queue_count;
    logic [VW-1:0]       read_parent;
    logic [WB-1:0]       read_weight;
    logic [STATUS_W-1:0] read_status;
    logic [VW-1:0]       removed_parent;
    logic [WB-1:0]       removed_weight;
    logic [VW-1:0]       removed_vertex;
  } pq_res_t;

  localparam int RES_W = $bits(pq_res_t);

  // Mirror of the queue contents; predicts the result of each accepted request.
  class min_queue_model;
    logic [VW-1:0]       vcount;
    logic [STATUS_W-1:0] status [0:MAXV];
    logic [WB-1:0]       weight [0:MAXV];
    logic [VW-1:0]       parent [0:MAXV];
    bit                  written [0:MAXV];
    int unsigned         fringe_cnt;
    int unsigned         failures;
    pq_res_t             awaited_results [$];

    function new();
      vcount = VW'(MAXV);
      foreach (status[v]) begin
        status[v]  = amq_pkg::ENT_UNSEEN;
        written[v] = 1'b0;
      end
      fringe_cnt = 0;
      failures   = 0;
    endfunction

    function int unsigned active_count();
      return (vcount > MAXV) ? MAXV : vcount;
    endfunction

    function bit in_range(logic [VW-1:0] v);
      return v >= 1 && v <= active_count();
    endfunction

    function void apply_request(pq_req_t req);
      pq_res_t     want;
      int unsigned best;
      logic [WB-1:0] best_w;
      logic        bad;
      want   = '0;
      bad    = 1'b0;
      best   = 0;
      best_w = '0;
      case (req.mode)
        amq_pkg::MODE_INSERT: begin
          if (!in_range(req.vertex) || status[req.vertex] != amq_pkg::ENT_UNSEEN) begin
            bad = 1'b1;
          end else begin
            status[req.vertex]  = amq_pkg::ENT_FRINGE;
            weight[req.vertex]  = req.weight;
            parent[req.vertex]  = req.parent;
            written[req.vertex] = 1'b1;
            fringe_cnt++;
          end
        end
        amq_pkg::MODE_DECREASE: begin
          if (!in_range(req.vertex) || status[req.vertex] != amq_pkg::ENT_FRINGE) begin
            bad = 1'b1;
          end else begin
            weight[req.vertex] = req.weight;
            parent[req.vertex] = req.parent;
          end
        end
        amq_pkg::MODE_DELETE: begin
          // Strict less-than keeps the lowest index on a tie.
          for (int v = 1; v <= active_count(); v++) begin
            if (status[v] == amq_pkg::ENT_FRINGE && (best == 0 || weight[v] < best_w)) begin
              best   = v;
              best_w = weight[v];
            end
          end
          // Fringe vertices above vertex_count are invisible to the scan.
          if (fringe_cnt == 0 || best == 0) begin
            bad = 1'b1;
          end else begin
            want.removed_vertex = VW'(best);
            want.removed_weight = best_w;
            want.removed_parent = parent[best];
            status[best] = amq_pkg::ENT_TREE;
            fringe_cnt--;
          end
        end
        amq_pkg::MODE_READ: begin
          if (!in_range(req.vertex)) begin
            bad = 1'b1;
          end else begin
            want.read_status = status[req.vertex];
            want.read_weight = weight[req.vertex];
            want.read_parent = parent[req.vertex];
          end
        end
        amq_pkg::MODE_CLEAR: begin
          foreach (status[v]) status[v] = amq_pkg::ENT_UNSEEN;
          fringe_cnt = 0;
        end
        default: bad = 1'b1;
      endcase
      want.queue_count = VW'(fringe_cnt);
      want.queue_empty = (fringe_cnt == 0);
      want.error       = bad;
      awaited_results.push_back(want);
    endfunction

    function void check_field(string name, logic [WB-1:0] want, logic [WB-1:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        failures++;
      end
    endfunction

    function void compare_result(pq_res_t got);
      pq_res_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      check_field("removed_vertex", want.removed_vertex, got.removed_vertex);
      check_field("removed_weight", want.removed_weight, got.removed_weight);
      check_field("removed_parent", want.removed_parent, got.removed_parent);
      check_field("read_status", want.read_status, got.read_status);
      check_field("read_weight", want.read_weight, got.read_weight);
      check_field("read_parent", want.read_parent, got.read_parent);
      check_field("queue_count", want.queue_count, got.queue_count);
      check_field("queue_empty", want.queue_empty, got.queue_empty);
      check_field("error", want.error, got.error);
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  min_queue_model queue_model;
  int unsigned    send_idle_pct    = 9;
  int unsigned    recv_idle_pct    = 50;
  bit             hold_off_pending = 1'b0;
  int unsigned    quiet_cycles     = 0;

  array_min_priority_queue u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      queue_model.compare_result(m_axis_tdata[RES_W-1:0]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on demand.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_pending = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic pq_req_t request_of(logic [MODE_W-1:0] mode, logic [VW-1:0] vertex,
                                         logic [VW-1:0] parent, logic [WB-1:0] weight);
    pq_req_t req;
    req.mode   = mode;
    req.vertex = vertex;
    req.parent = parent;
    req.weight = weight;
    return req;
  endfunction

  // Finds a vertex of the wanted kind, starting at a random point; 0 if none.
  function automatic logic [VW-1:0] pick_vertex(pick_e kind);
    int unsigned ac;
    int unsigned start;
    int unsigned v;
    ac = queue_model.active_count();
    if (ac == 0) return '0;
    start = $urandom_range(1, ac);
    for (int unsigned k = 0; k < ac; k++) begin
      v = (start - 1 + k) % ac + 1;
      if ((kind == PICK_UNSEEN && queue_model.status[v] == amq_pkg::ENT_UNSEEN) ||
          (kind == PICK_FRINGE && queue_model.status[v] == amq_pkg::ENT_FRINGE) ||
          (kind == PICK_WRITTEN && queue_model.written[v])) begin
        return VW'(v);
      end
    end
    return '0;
  endfunction

  function automatic logic [WB-1:0] random_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return WB'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic pq_req_t random_request();
    pq_req_t     req;
    int unsigned sel;
    int unsigned ac;
    ac         = queue_model.active_count();
    req.weight = random_weight();
    req.parent = ($urandom_range(0, 9) == 0) ? VW'($urandom_range(0, 511))
                                              : VW'($urandom_range(0, 256));
    req.vertex = VW'($urandom_range(0, 511));
    sel        = $urandom_range(0, 99);
    if (sel < 1) begin
      req.mode = amq_pkg::MODE_CLEAR;
    end else if (sel < 3) begin
      req.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    end else if (sel < 6) begin
      req.mode = MODE_W'($urandom_range(0, 7));
    end else begin
      // Mostly legal requests, so the queue gets deep and drains in order.
      sel = $urandom_range(0, 99);
      if (sel < 35 || (queue_model.fringe_cnt == 0 && sel < 75)) begin
        req.mode   = amq_pkg::MODE_INSERT;
        req.vertex = pick_vertex(PICK_UNSEEN);
        if (req.vertex == 0 && $urandom_range(0, 1) == 1) req.mode = amq_pkg::MODE_CLEAR;
      end else if (sel < 55) begin
        req.mode   = amq_pkg::MODE_DECREASE;
        req.vertex = pick_vertex(PICK_FRINGE);
      end else if (sel < 85) begin
        req.mode = amq_pkg::MODE_DELETE;
      end else begin
        req.mode   = amq_pkg::MODE_READ;
        req.vertex = pick_vertex(PICK_WRITTEN);
      end
      if ($urandom_range(0, 99) < 8) begin
        req.vertex = ($urandom_range(0, 1) == 1) ? '0 : VW'($urandom_range(ac + 1, 511));
      end
    end
    // A read must never land on an entry that was never written.
    if (req.mode == amq_pkg::MODE_READ && queue_model.in_range(req.vertex) &&
        !queue_model.written[req.vertex]) begin
      req.vertex = '0;
    end
    return req;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i); while (queue_model.awaited_results.size() != 0);
  endtask

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_request(pq_req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= IN_DW'(req);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    queue_model.apply_request(req);
  endtask

  task automatic write_vertex_count(logic [VW-1:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= VC_ADDR;
    pwdata  <= {23'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    queue_model.vcount = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DW'(value)) begin
      $error("vertex_count readback: expected %0d, got %0d", value, prdata);
      queue_model.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [VW-1:0] value, int count, bit pause_midway, bit stall_midway);
    write_vertex_count(value);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      if (stall_midway && i == 40) hold_off_pending = 1'b1;
      send_request(random_request());
    end
  endtask

  initial begin
    queue_model = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset vertex_count.
    send_request(request_of(amq_pkg::MODE_DELETE, 9'd0, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_READ, 9'd0, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_INSERT, 9'd256, 9'd256, '1));
    send_request(request_of(amq_pkg::MODE_INSERT, 9'd1, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_INSERT, 9'd1, 9'd5, 32'd9));
    send_request(request_of(amq_pkg::MODE_INSERT, 9'd257, 9'd1, 32'd3));
    send_request(request_of(amq_pkg::MODE_DECREASE, 9'd2, 9'd1, 32'd1));
    send_request(request_of(amq_pkg::MODE_INSERT, 9'd5, 9'd1, 32'd7));
    send_request(request_of(amq_pkg::MODE_INSERT, 9'd3, 9'd1, 32'd7));
    send_request(request_of(amq_pkg::MODE_DECREASE, 9'd256, 9'd3, 32'd5));
    send_request(request_of(amq_pkg::MODE_DECREASE, 9'd1, 9'd3, 32'd100));
    send_request(request_of(amq_pkg::MODE_READ, 9'd256, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_DELETE, 9'd0, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_DELETE, 9'd0, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_DECREASE, 9'd3, 9'd2, 32'd1));
    send_request(request_of(amq_pkg::MODE_READ, 9'd3, 9'd0, '0));
    send_request(request_of(MODE_UNUSED_LO, 9'd1, 9'd0, '0));
    send_request(request_of(MODE_UNUSED_HI, 9'd511, 9'd511, 32'hA5A5_5A5A));
    send_request(request_of(amq_pkg::MODE_INSERT, 9'd200, 9'd100, 32'd42));
    send_request(request_of(amq_pkg::MODE_READ, 9'd511, 9'd0, '0));

    // Shrinking the range hides the fringe vertices 5 and 200 from the scan.
    write_vertex_count(9'd2);
    send_request(request_of(amq_pkg::MODE_DELETE, 9'd0, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_DELETE, 9'd0, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_READ, 9'd5, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_CLEAR, 9'd0, 9'd0, '0));
    send_request(request_of(amq_pkg::MODE_READ, 9'd1, 9'd0, '0));

    run_phase(9'd256, 200, 1'b1, 1'b0);
    run_phase(9'd1, 40, 1'b0, 1'b0);

    send_idle_pct = 50;
    recv_idle_pct = 9;
    run_phase(9'd16, 200, 1'b0, 1'b0);
    run_phase(9'd511, 100, 1'b0, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(9'd3, 80, 1'b0, 1'b0);
    run_phase(9'd64, 250, 1'b0, 1'b1);
    run_phase(9'd0, 20, 1'b0, 1'b0);
    run_phase(9'd256, 100, 1'b0, 1'b0);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (queue_model.failures == 0 && queue_model.awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
